[rtl/spmq_pkg.sv]
// Package with the types, constants and codes of the strict priority multi-queue.
package spmq_pkg;

  localparam int MAX_LEVELS = 16;
  localparam int CAPACITY   = 64;
  localparam int TAG_W      = 32;

  localparam int LV_W  = 4;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LV_W-1:0]  lv_t;
  typedef logic [TAG_W-1:0] stag_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_NEXT  = 2'd1,
    ACT_ERASE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ZERO_POS  = 3'd4,
    ST_NO_ENTRY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  level;
    logic [31:0] tag;
    logic [6:0]  position;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] tag_out;
  } out_data_t;

  typedef struct packed {
    lv_t   lv;
    stag_t tag;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    cnt_t     count;
    lv_t      new_lv;
    stag_t    new_tag;
    idx_t     rm_idx;
  } cell_ctrl_t;

endpackage

[rtl/spmq_cell.sv]
// One cell of the sorted chain: holds a single entry and shifts with its neighbors.
module spmq_cell
  import spmq_pkg::*;
(
  input  logic       clk,
  input  idx_t       cell_idx,
  input  cell_ctrl_t ctrl,
  input  logic       prev_ge,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       ge,
  output entry_t     entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   valid;

  assign valid = cnt_t'(cell_idx) < ctrl.count;
  // The chain is sorted by descending level, so these flags form a run of ones.
  assign ge    = valid && (entry_r.lv >= ctrl.new_lv);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            entry_nxt.lv  = ctrl.new_lv;
            entry_nxt.tag = ctrl.new_tag;
          end else begin
            entry_nxt = left_entry;
          end
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctrl.rm_idx) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/strict_priority_multi_queue_core.sv]
// A request's result is registered and shown in the cycle after acceptance.
// One request per cycle unless the output stalls; every cell compares and shifts
// in parallel, so add, next and erase each finish in the cycle they are accepted.
// Reset (rst_n low, synchronous): entry count, level count and output valid clear.
// The cell contents are not reset; only cells below the entry count are read.
// A nonzero level count write empties the store at once.
module strict_priority_multi_queue_core
  import spmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data,
  input  logic      cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  logic       out_valid_r, out_valid_nxt;
  out_data_t  out_data_r, out_data_nxt;
  cnt_t       count_r, count_nxt;
  logic [4:0] num_levels_r, num_levels_nxt;

  logic       in_fire;
  status_t    status;
  cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] ge;
  entry_t     cells [CAPACITY];

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Request decode and check.
  always_comb begin
    status       = ST_OK;
    ctrl.op      = CELL_HOLD;
    ctrl.count   = count_r;
    ctrl.new_lv  = lv_t'(in_data.level - 5'd1);
    ctrl.new_tag = stag_t'(64'(in_data.tag));
    ctrl.rm_idx  = idx_t'(in_data.position - 7'd1);
    case (in_data.action)
      ACT_ADD: begin
        if (in_data.level == 5'd0 || in_data.level > num_levels_r) begin
          status = ST_BAD_LEVEL;
        end else if (count_r >= cnt_t'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
        end
      end
      ACT_NEXT: begin
        ctrl.rm_idx = '0;
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          ctrl.op = CELL_REMOVE;
        end
      end
      ACT_ERASE: begin
        if (in_data.position == 7'd0) begin
          status = ST_ZERO_POS;
        end else if (8'(in_data.position) > 8'(count_r)) begin
          status = ST_NO_ENTRY;
        end else begin
          ctrl.op = CELL_REMOVE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (!in_fire) begin
      ctrl.op = CELL_HOLD;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic   prev_ge;
      entry_t left_entry;
      entry_t right_entry;
      if (i == 0) begin : g_first
        assign prev_ge    = 1'b1;
        assign left_entry = cells[i];
      end else begin : g_mid
        assign prev_ge    = ge[i-1];
        assign left_entry = cells[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_entry = cells[i];
      end else begin : g_inner
        assign right_entry = cells[i+1];
      end
      spmq_cell u_cell (
        .clk         (clk),
        .cell_idx    (idx_t'(i)),
        .ctrl        (ctrl),
        .prev_ge     (prev_ge),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .ge          (ge[i]),
        .entry       (cells[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt      = count_r;
    num_levels_nxt = num_levels_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.status  = status;
      out_data_nxt.tag_out = '0;
      if (ctrl.op == CELL_INSERT) begin
        count_nxt = count_r + cnt_t'(1);
      end else if (ctrl.op == CELL_REMOVE) begin
        count_nxt = count_r - cnt_t'(1);
        if (in_data.action == ACT_NEXT) begin
          out_data_nxt.tag_out = 32'(cells[0].tag);
        end
      end
    end
    if (cfg_wr_en && cfg_wr_data != 5'd0) begin
      num_levels_nxt = (cfg_wr_data > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : cfg_wr_data;
      count_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      num_levels_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      num_levels_r <= num_levels_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ctrl.op == CELL_INSERT && !cfg_wr_en) |=> count_r == $past(count_r) + cnt_t'(1))
    else $error("accepted add did not grow the store");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ctrl.op == CELL_REMOVE && !cfg_wr_en) |=> count_r == $past(count_r) - cnt_t'(1))
    else $error("accepted removal did not shrink the store");

  a_tag_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.tag_out != '0) |-> out_data_r.status == ST_OK)
    else $error("nonzero tag with a failing status");

  a_levels_bound: assert property (@(posedge clk) disable iff (!rst_n)
    num_levels_r <= 5'(MAX_LEVELS))
    else $error("level count above maximum");

endmodule

[sim/strict_priority_multi_queue_core_test.sv]
// Self-checking testbench for the strict priority multi-queue core.
module strict_priority_multi_queue_core_test;
  import spmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_REQUESTS = 190;
  localparam int unsigned NUM_PHASES = 6;

  class priority_store_model;
    stag_t       tags[CAPACITY];
    lv_t         lvls[CAPACITY];
    int unsigned count;
    int unsigned levels_in_use;
    out_data_t   answers[$];
    int unsigned errors;

    function void set_level_count(logic [4:0] value);
      if (value == 0) return;
      levels_in_use = (value > MAX_LEVELS) ? MAX_LEVELS : value;
      count = 0;
    endfunction

    function void drop_entry(int unsigned slot);
      for (int unsigned i = slot; i + 1 < count; i++) begin
        tags[i] = tags[i + 1];
        lvls[i] = lvls[i + 1];
      end
      count--;
    endfunction

    // Updates the store for one accepted request and queues its answer.
    function void take_request(in_data_t req);
      out_data_t ans;
      lv_t       lv;
      int unsigned slot;
      ans = '0;
      case (req.action)
        ACT_ADD: begin
          if (req.level == 0 || req.level > levels_in_use) begin
            ans.status = ST_BAD_LEVEL;
          end else if (count >= CAPACITY) begin
            ans.status = ST_FULL;
          end else begin
            lv = lv_t'(req.level - 1);
            slot = 0;
            // A new entry goes behind every entry of the same or a higher level.
            while (slot < count && lvls[slot] >= lv) slot++;
            for (int unsigned i = count; i > slot; i--) begin
              tags[i] = tags[i - 1];
              lvls[i] = lvls[i - 1];
            end
            tags[slot] = req.tag;
            lvls[slot] = lv;
            count++;
          end
        end
        ACT_NEXT: begin
          if (count == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            ans.tag_out = tags[0];
            drop_entry(0);
          end
        end
        ACT_ERASE: begin
          if (req.position == 0) ans.status = ST_ZERO_POS;
          else if (req.position > count) ans.status = ST_NO_ENTRY;
          else drop_entry(req.position - 1);
        end
        default: ans = '0;
      endcase
      answers.push_back(ans);
    endfunction

    function void check_answer(out_data_t got);
      out_data_t want;
      if (answers.size() == 0) begin
        $error("result with no request outstanding: status %0d tag_out %h",
               got.status, got.tag_out);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.tag_out !== want.tag_out) begin
        $error("tag_out: expected %h, actual %h", want.tag_out, got.tag_out);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_data_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_data_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  priority_store_model book = new();

  int unsigned level_plan[NUM_PHASES] = '{16, 1, 5, 31, 0, 3};
  int unsigned add_plan[NUM_PHASES]   = '{80, 45, 50, 40, 45, 55};
  int unsigned next_plan[NUM_PHASES]  = '{8, 25, 22, 25, 25, 20};

  strict_priority_multi_queue_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_answer(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("strict_priority_multi_queue_core verification failed");
      $finish;
    end
  end

  function automatic in_data_t make_request(logic [1:0] action, logic [4:0] level,
                                            logic [31:0] tag, logic [6:0] position);
    in_data_t req;
    req.action = action;
    req.level = level;
    req.tag = tag;
    req.position = position;
    return req;
  endfunction

  // Mostly levels in range and positions near the live entries, with some noise.
  function automatic in_data_t random_request(int unsigned add_pct, int unsigned next_pct);
    in_data_t req;
    int unsigned roll;
    roll = $urandom_range(99);
    req.tag = $urandom;
    if ($urandom_range(99) < 85 && book.levels_in_use != 0)
      req.level = 5'($urandom_range(book.levels_in_use, 1));
    else
      req.level = 5'($urandom_range(31, 0));
    if ($urandom_range(99) < 85)
      req.position = 7'($urandom_range(book.count + 1, 1));
    else
      req.position = 7'($urandom_range(127, 0));
    if (roll < 3) req.action = ACT_UNUSED;
    else if (roll < 3 + add_pct) req.action = ACT_ADD;
    else if (roll < 3 + add_pct + next_pct) req.action = ACT_NEXT;
    else req.action = ACT_ERASE;
    return req;
  endfunction

  // Holds the request until it is accepted; valid stays high afterwards.
  task automatic send_request(input in_data_t req);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    book.take_request(req);
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (book.answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_level_count(input logic [4:0] value);
    drain_answers();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    book.set_level_count(value);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Store not yet initialized.
    send_request(make_request(ACT_ADD, 5'd1, 32'h1111_1111, 7'd0));
    send_request(make_request(ACT_NEXT, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd1));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_UNUSED, 5'd3, 32'h5555_aaaa, 7'd9));
    write_level_count(5'd0);
    send_request(make_request(ACT_ADD, 5'd1, 32'h2222_2222, 7'd0));

    // A count above the maximum saturates.
    write_level_count(5'd31);
    send_request(make_request(ACT_ADD, 5'd16, 32'hffff_ffff, 7'd0));
    send_request(make_request(ACT_ADD, 5'd1, 32'h0000_0000, 7'd0));
    send_request(make_request(ACT_ADD, 5'd16, 32'h1234_5678, 7'd0));
    send_request(make_request(ACT_ADD, 5'd17, 32'hdead_beef, 7'd0));
    send_request(make_request(ACT_ADD, 5'd0, 32'hdead_beef, 7'd0));
    send_request(make_request(ACT_ADD, 5'd31, 32'hdead_beef, 7'd0));
    send_request(make_request(ACT_ADD, 5'd8, 32'ha5a5_a5a5, 7'd0));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd127));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd5));
    send_request(make_request(ACT_ERASE, 5'd0, 32'h0, 7'd2));
    send_request(make_request(ACT_NEXT, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_NEXT, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_NEXT, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_NEXT, 5'd0, 32'h0, 7'd0));
    send_request(make_request(ACT_UNUSED, 5'd31, 32'hffff_ffff, 7'd127));

    // The first phase is add-heavy so that the store fills up; a zero write
    // in a later phase keeps the entries already stored.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_level_count(5'(level_plan[p]));
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_REQUESTS; n++)
        send_request(random_request(add_plan[p], next_plan[p]));
    end
    no_idle = 1'b0;

    drain_answers();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.answers.size() == 0) begin
      $display("strict_priority_multi_queue_core verification clean");
    end else begin
      if (book.answers.size() != 0)
        $error("%0d expected results never arrived", book.answers.size());
      $display("strict_priority_multi_queue_core verification failed");
    end
    $finish;
  end

endmodule
